>>> rtl/json_string_unescape_utf8_assert.svh
// assertion macros for the json string unescaper
// expects clk and arst_n in the scope where they are used
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jsu_pkg.sv
// shared types and constants for the json string unescaper
// no dependencies
`timescale 1ns / 1ps

package jsu_pkg;

	// result status codes
	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam int CP_W   = 21;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one command from the parser: a code point to encode, a raw string byte
	// to pass through as it is, or done / error
	typedef struct packed {
		logic [1:0]      status;
		logic            raw;
		logic [CP_W-1:0] cp;
	} cmd_t;

	// queue head as seen by the encoder
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

>>> rtl/jsu_front.sv
// parser front end: takes input bytes, tracks escapes and surrogate pairs
// depends on jsu_pkg; pushes one command per result run into the queue
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tlast,   // end_of_input
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	localparam logic [2:0] PH_WAIT   = 3'd0;
	localparam logic [2:0] PH_STR    = 3'd1;
	localparam logic [2:0] PH_ESC    = 3'd2;
	localparam logic [2:0] PH_HEX    = 3'd3;
	localparam logic [2:0] PH_PAIRBS = 3'd4;
	localparam logic [2:0] PH_PAIRU  = 3'd5;

	logic [2:0]  phase_q, phase_n;
	logic [15:0] hex_accum_q, hex_accum_n;
	logic [1:0]  hex_cnt_q, hex_cnt_n;
	logic [15:0] high_q, high_n;
	logic        low_quad_q, low_quad_n;

	logic        accept;
	logic        err;
	logic        digit_ok;
	logic [3:0]  nib;
	logic [15:0] acc_new;
	logic        push_c;
	cmd_t        cmd_c;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;
	assign push     = accept && push_c;
	assign push_cmd = cmd_c;

	always_comb begin
		digit_ok = 1'b1;
		nib      = 4'd0;
		if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
			nib = s_tdata[3:0];
		end else if ((s_tdata >= 8'h61 && s_tdata <= 8'h66) ||
		             (s_tdata >= 8'h41 && s_tdata <= 8'h46)) begin
			nib = s_tdata[3:0] + 4'd9;
		end else begin
			digit_ok = 1'b0;
		end
	end

	assign acc_new = {hex_accum_q[11:0], nib};

	always_comb begin
		phase_n     = phase_q;
		hex_accum_n = hex_accum_q;
		hex_cnt_n   = hex_cnt_q;
		high_n      = high_q;
		low_quad_n  = low_quad_q;
		err         = 1'b0;
		push_c      = 1'b0;
		cmd_c       = '0;

		if (s_tlast) begin
			err = 1'b1;
		end else begin
			unique case (phase_q)
				PH_STR: begin
					if (s_tdata == 8'h22) begin
						phase_n      = PH_WAIT;
						push_c       = 1'b1;
						cmd_c.status = ST_DONE;
					end else if (s_tdata == 8'h5C) begin
						phase_n = PH_ESC;
					end else begin
						// string bytes leave unchanged, even above 0x7f
						push_c    = 1'b1;
						cmd_c.raw = 1'b1;
						cmd_c.cp  = {13'd0, s_tdata};
					end
				end
				PH_ESC: begin
					push_c  = 1'b1;
					phase_n = PH_STR;
					unique case (s_tdata)
						8'h22, 8'h5C, 8'h2F: cmd_c.cp = {13'd0, s_tdata};
						8'h62: cmd_c.cp = 21'h08;
						8'h66: cmd_c.cp = 21'h0C;
						8'h6E: cmd_c.cp = 21'h0A;
						8'h72: cmd_c.cp = 21'h0D;
						8'h74: cmd_c.cp = 21'h09;
						8'h75: begin
							push_c      = 1'b0;
							phase_n     = PH_HEX;
							low_quad_n  = 1'b0;
							hex_accum_n = 16'd0;
							hex_cnt_n   = 2'd0;
						end
						default: err = 1'b1;
					endcase
				end
				PH_HEX: begin
					if (!digit_ok) begin
						err = 1'b1;
					end else begin
						hex_accum_n = acc_new;
						hex_cnt_n   = hex_cnt_q + 2'd1;
						if (hex_cnt_q == 2'd3) begin
							if (!low_quad_q) begin
								if (acc_new < 16'hD800 || acc_new > 16'hDBFF) begin
									phase_n  = PH_STR;
									push_c   = 1'b1;
									cmd_c.cp = {5'd0, acc_new};
								end else begin
									high_n  = acc_new;
									phase_n = PH_PAIRBS;
								end
							end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
								err = 1'b1;
							end else begin
								// high holds 110110xx_xxxxxxxx, so only the low ten bits matter
								low_quad_n = 1'b0;
								phase_n    = PH_STR;
								push_c     = 1'b1;
								cmd_c.cp   = {1'b0, high_q[9:0], acc_new[9:0]} + 21'h10000;
							end
						end
					end
				end
				PH_PAIRBS: begin
					if (s_tdata != 8'h5C) err = 1'b1;
					else phase_n = PH_PAIRU;
				end
				PH_PAIRU: begin
					if (s_tdata != 8'h75) begin
						err = 1'b1;
					end else begin
						phase_n     = PH_HEX;
						low_quad_n  = 1'b1;
						hex_accum_n = 16'd0;
						hex_cnt_n   = 2'd0;
					end
				end
				default: begin
					phase_n = PH_WAIT;
					if (s_tdata == 8'h22) begin
						phase_n = PH_STR;
					end else if (!(s_tdata == 8'h20 || (s_tdata >= 8'h09 && s_tdata <= 8'h0D))) begin
						err = 1'b1;
					end
				end
			endcase
		end

		if (err) begin
			phase_n      = PH_WAIT;
			low_quad_n   = 1'b0;
			hex_cnt_n    = 2'd0;
			push_c       = 1'b1;
			cmd_c        = '0;
			cmd_c.status = ST_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			hex_accum_q <= 16'd0;
			hex_cnt_q   <= 2'd0;
			high_q      <= 16'd0;
			low_quad_q  <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			hex_accum_q <= hex_accum_n;
			hex_cnt_q   <= hex_cnt_n;
			high_q      <= high_n;
			low_quad_q  <= low_quad_n;
		end
	end

endmodule

>>> rtl/jsu_queue.sv
// short command queue between parser and encoder
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_cmd,
	output logic   full,
	input  logic   pop,
	output qhead_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/jsu_back.sv
// encoder back end: turns queued commands into utf-8 result transfers
// depends on jsu_pkg; drives the registered output stream
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  qhead_t     head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // status
	output logic       m_tlast    // last_of_run
);

	logic            valid_q;
	logic [7:0]      byte_q;
	logic [1:0]      status_q;
	logic            last_q;
	logic [1:0]      idx_q;

	logic            load;
	logic [1:0]      nb_m1;
	logic [7:0]      byte_c;
	logic            last_c;
	logic [CP_W-1:0] cp;

	assign cp       = head.cmd.cp;
	assign load     = head.valid && (!valid_q || m_tready);
	assign last_c   = (idx_q == nb_m1);
	assign pop      = load && last_c;

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	// raw string bytes are a single transfer of the byte itself
	always_comb begin
		if (head.cmd.status != ST_DATA || head.cmd.raw) nb_m1 = 2'd0;
		else if (cp <= 21'h7F)          nb_m1 = 2'd0;
		else if (cp <= 21'h7FF)         nb_m1 = 2'd1;
		else if (cp <= 21'hFFFF)        nb_m1 = 2'd2;
		else                            nb_m1 = 2'd3;
	end

	always_comb begin
		byte_c = 8'd0;
		if (head.cmd.status == ST_DATA) begin
			if (idx_q == 2'd0) begin
				unique case (nb_m1)
					2'd0: byte_c = cp[7:0];
					2'd1: byte_c = {3'b110, cp[10:6]};
					2'd2: byte_c = {4'b1110, cp[15:12]};
					2'd3: byte_c = {5'b11110, cp[20:18]};
				endcase
			end else begin
				// continuation byte: six bits counted down from the lead
				unique case (nb_m1 - idx_q)
					2'd0: byte_c = {2'b10, cp[5:0]};
					2'd1: byte_c = {2'b10, cp[11:6]};
					2'd2: byte_c = {2'b10, cp[17:12]};
					2'd3: byte_c = {2'b10, cp[5:0]};
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_c;
			status_q <= head.cmd.status;
			last_q   <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_c ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/json_string_unescape_utf8.sv
// JSON string unescaper with utf-8 encoding of \u escapes: top level.
// Takes one input byte per cycle. Each result run (a data byte, the 1 to 4
// bytes of an encoded code point, a done or an error) leaves as one output
// transfer per byte, one per cycle while m_tready is high; a \u escape that
// expands to a multi-byte sequence keeps the encoder busy until its last
// byte is loaded, and a two-entry command queue lets the parser go on taking
// bytes meanwhile. Input is held off only when that queue is full.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back and the assertion header.
`timescale 1ns / 1ps

`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tlast,   // end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // status
	output logic       m_tlast    // last_of_run
);

	logic   push;
	cmd_t   push_cmd;
	logic   q_full;
	logic   pop;
	qhead_t head;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	jsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// done and error are single-transfer runs with a zero byte
	`JSU_ASSERT(a_ctrl_run, m_tvalid && m_tuser != ST_DATA, m_tlast && m_tdata == 8'd0, "control result malformed")
	// end of input always queues an error
	`JSU_ASSERT(a_eoi_err, s_tvalid && s_tready && s_tlast, push && push_cmd.status == ST_ERR, "end of input without error")
	// output only fills from a queued command
	`JSU_ASSERT_NEXT(a_no_phantom, !head.valid && !(m_tvalid && !m_tready), !m_tvalid, "output valid with empty queue")

endmodule

>>> tb/tb_top.sv
// self-checking bench for json_string_unescape_utf8: directed table plus random strings
// predicts output with a byte-level unescaper model or takes typed-in results; needs jsu_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
	import jsu_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int HOLD_CYCLES = 120;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		WAIT_QUOTE, IN_STRING, IN_ESCAPE, IN_HEX, PAIR_BSLASH, PAIR_U
	} parse_phase_t;

	// how a table row is checked: by the predictor, by the typed-in result, or not at all
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		row_check_t chk;
		logic [7:0] want_byte;
		logic [1:0] want_status;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
	} in_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	json_string_unescape_utf8 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	parse_phase_t parse_ph = WAIT_QUOTE;
	logic [15:0]  quad_acc = '0;
	logic [1:0]   quad_digits = '0;
	logic [15:0]  pending_high = '0;
	logic         second_quad = 1'b0;

	result_t  step_out[$];
	result_t  expected_out[$];
	in_item_t stim_q[$];

	int tx_idle_pct = 18;
	int rx_idle_pct = 58;
	bit hold_req = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int inputs_sent = 0;
	int results_seen = 0;
	int done_seen = 0;
	int err_seen = 0;

	logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};

	stim_row_t dir_rows [24] = '{
		'{8'h00,     1'b1, CHK_ONE,   8'h00, ST_ERR},   // end of input while waiting
		'{CH_SPACE,  1'b0, CHK_NONE,  8'h00, ST_DATA},
		'{8'h09,     1'b0, CHK_NONE,  8'h00, ST_DATA},
		'{8'h0D,     1'b0, CHK_NONE,  8'h00, ST_DATA},
		'{8'h41,     1'b0, CHK_ONE,   8'h00, ST_ERR},   // stray byte before the quote
		'{CH_QUOTE,  1'b0, CHK_NONE,  8'h00, ST_DATA},
		'{8'hFF,     1'b0, CHK_ONE,   8'hFF, ST_DATA},
		'{CH_BSLASH, 1'b0, CHK_NONE,  8'h00, ST_DATA},
		'{"t",       1'b0, CHK_ONE,   8'h09, ST_DATA},
		'{CH_BSLASH, 1'b0, CHK_MODEL, 8'h00, ST_DATA},  // highest pair: U+10FFFF
		'{CH_U,      1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"D",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"b",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"F",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"f",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{CH_U,      1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"D",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"F",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"f",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{"F",       1'b0, CHK_MODEL, 8'h00, ST_DATA},
		'{CH_QUOTE,  1'b0, CHK_ONE,   8'h00, ST_DONE},
		'{CH_QUOTE,  1'b0, CHK_NONE,  8'h00, ST_DATA},
		'{8'h00,     1'b1, CHK_ONE,   8'h00, ST_ERR}    // end of input inside a string
	};

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - 8'h30);
		if (c >= "a" && c <= "f")
			return int'(c - 8'h61) + 10;
		if (c >= "A" && c <= "F")
			return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	// byte i of the sequence sits in seq[8*i +: 8]
	function automatic void utf8_encode(input logic [20:0] cp, output int n,
			output logic [31:0] seq);
		seq = '0;
		if (cp <= 21'h7F) begin
			n = 1;
			seq[7:0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			n = 2;
			seq[7:0]   = 8'hC0 | cp[10:6];
			seq[15:8]  = 8'h80 | cp[5:0];
		end else if (cp <= 21'hFFFF) begin
			n = 3;
			seq[7:0]   = 8'hE0 | cp[15:12];
			seq[15:8]  = 8'h80 | cp[11:6];
			seq[23:16] = 8'h80 | cp[5:0];
		end else begin
			n = 4;
			seq[7:0]   = 8'hF0 | cp[20:18];
			seq[15:8]  = 8'h80 | cp[17:12];
			seq[23:16] = 8'h80 | cp[11:6];
			seq[31:24] = 8'h80 | cp[5:0];
		end
	endfunction

	// advance the unescaper by one input byte; fills step_out with the run it causes
	function automatic void predict_unescape(input logic [7:0] c, input logic eoi);
		logic [31:0] seq;
		logic [1:0]  st;
		logic        bad;
		int          n;
		int          d;
		result_t     r;
		seq = '0;
		st = ST_DATA;
		bad = 1'b0;
		n = 0;
		step_out.delete();
		if (eoi)
			bad = 1'b1;
		else case (parse_ph)
			IN_STRING: begin
				if (c == CH_QUOTE) begin
					parse_ph = WAIT_QUOTE;
					st = ST_DONE;
					n = 1;
				end else if (c == CH_BSLASH) begin
					parse_ph = IN_ESCAPE;
				end else begin
					seq[7:0] = c;
					n = 1;
				end
			end
			IN_ESCAPE: begin
				n = 1;
				parse_ph = IN_STRING;
				case (c)
					CH_QUOTE, CH_BSLASH, CH_SLASH: seq[7:0] = c;
					"b": seq[7:0] = 8'h08;
					"f": seq[7:0] = 8'h0C;
					"n": seq[7:0] = 8'h0A;
					"r": seq[7:0] = 8'h0D;
					"t": seq[7:0] = 8'h09;
					CH_U: begin
						n = 0;
						parse_ph = IN_HEX;
						second_quad = 1'b0;
						quad_acc = '0;
						quad_digits = '0;
					end
					default: bad = 1'b1;
				endcase
			end
			IN_HEX: begin
				d = hex_nibble(c);
				if (d < 0) begin
					bad = 1'b1;
				end else begin
					quad_acc = {quad_acc[11:0], d[3:0]};
					if (quad_digits != 2'd3) begin
						quad_digits = quad_digits + 2'd1;
					end else begin
						quad_digits = '0;
						if (!second_quad) begin
							if (quad_acc < 16'hD800 || quad_acc > 16'hDBFF) begin
								parse_ph = IN_STRING;
								utf8_encode({5'd0, quad_acc}, n, seq);
							end else begin
								pending_high = quad_acc;
								parse_ph = PAIR_BSLASH;
							end
						end else if (quad_acc < 16'hDC00 || quad_acc > 16'hDFFF) begin
							bad = 1'b1;
						end else begin
							second_quad = 1'b0;
							parse_ph = IN_STRING;
							// low ten bits of each half, offset past the basic plane
							utf8_encode(21'h10000 + {pending_high[9:0], quad_acc[9:0]}, n, seq);
						end
					end
				end
			end
			PAIR_BSLASH: begin
				if (c != CH_BSLASH)
					bad = 1'b1;
				else
					parse_ph = PAIR_U;
			end
			PAIR_U: begin
				if (c != CH_U) begin
					bad = 1'b1;
				end else begin
					parse_ph = IN_HEX;
					second_quad = 1'b1;
					quad_acc = '0;
					quad_digits = '0;
				end
			end
			default: begin
				parse_ph = WAIT_QUOTE;
				if (c == CH_QUOTE)
					parse_ph = IN_STRING;
				else if (!(c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)))
					bad = 1'b1;
			end
		endcase
		if (bad) begin
			parse_ph = WAIT_QUOTE;
			second_quad = 1'b0;
			quad_digits = '0;
			seq = '0;
			st = ST_ERR;
			n = 1;
		end
		for (int i = 0; i < n; i++) begin
			r = '{seq[8*i +: 8], st, i == n - 1};
			step_out.insert(step_out.size(), r);
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		if ($urandom_range(0, 1))
			return 8'h57 + {4'd0, v};
		return 8'h37 + {4'd0, v};
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic eoi = 1'b0);
		in_item_t it;
		it = '{b, eoi};
		stim_q.insert(stim_q.size(), it);
	endfunction

	function automatic void push_quad(input logic [15:0] q);
		push_byte(CH_BSLASH);
		push_byte(CH_U);
		for (int i = 3; i >= 0; i--)
			push_byte(hex_char(q[4*i +: 4]));
	endfunction

	function automatic logic [15:0] pick_code_unit();
		logic [15:0] q;
		logic [15:0] edges [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
		case ($urandom_range(0, 4))
			0: q = 16'($urandom_range(0, 16'h7F));
			1: q = 16'($urandom_range(16'h80, 16'h7FF));
			2: begin
				q = 16'($urandom_range(16'h800, 16'hFFFF));
				while (q >= 16'hD800 && q <= 16'hDBFF)
					q = 16'($urandom_range(16'h800, 16'hFFFF));
			end
			3: q = 16'($urandom_range(16'hDC00, 16'hDFFF));  // lone low half
			default: q = edges[$urandom_range(0, 5)];
		endcase
		return q;
	endfunction

	// one random segment: mostly well-formed strings, some broken, some stray bytes
	function automatic void gen_segment();
		int          kind;
		int          nel;
		int          k;
		logic [7:0]  b;
		logic [15:0] q;
		logic [7:0]  ws [6] = '{CH_SPACE, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			return;
		end
		repeat ($urandom_range(0, 2))
			push_byte(ws[$urandom_range(0, 5)]);
		push_byte(CH_QUOTE);
		nel = $urandom_range(0, 6);
		repeat (nel) begin
			k = $urandom_range(0, 99);
			if (k < 40) begin
				b = 8'($urandom_range(0, 255));
				while (b == CH_QUOTE || b == CH_BSLASH)
					b = 8'($urandom_range(0, 255));
				push_byte(b);
			end else if (k < 60) begin
				push_byte(CH_BSLASH);
				push_byte(esc_letters[$urandom_range(0, 7)]);
			end else if (k < 80) begin
				push_quad(pick_code_unit());
			end else begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				push_quad(16'($urandom_range(16'hDC00, 16'hDFFF)));
			end
		end
		if (kind >= 30) begin
			push_byte(CH_QUOTE);
			return;
		end
		case ($urandom_range(0, 6))
			0: push_byte(8'($urandom_range(0, 255)), 1'b1);
			1: begin
				b = 8'($urandom_range(0, 255));
				while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_U, "b", "f", "n", "r", "t"})
					b = 8'($urandom_range(0, 255));
				push_byte(CH_BSLASH);
				push_byte(b);
			end
			2, 6: begin
				push_byte(CH_BSLASH);
				push_byte(CH_U);
				repeat ($urandom_range(0, 3))
					push_byte(hex_char(4'($urandom_range(0, 15))));
				if (kind % 2) begin
					b = 8'($urandom_range(0, 255));
					while (hex_nibble(b) >= 0)
						b = 8'($urandom_range(0, 255));
					push_byte(b);
				end else begin
					push_byte(8'($urandom_range(0, 255)), 1'b1);
				end
			end
			3: begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				b = 8'($urandom_range(0, 255));
				while (b == CH_BSLASH)
					b = 8'($urandom_range(0, 255));
				push_byte(b);
			end
			4: begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				push_byte(CH_BSLASH);
				b = 8'($urandom_range(0, 255));
				while (b == CH_U)
					b = 8'($urandom_range(0, 255));
				push_byte(b);
			end
			default: begin
				push_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
				q = 16'($urandom_range(0, 16'hFFFF));
				while (q >= 16'hDC00 && q <= 16'hDFFF)
					q = 16'($urandom_range(0, 16'hFFFF));
				push_quad(q);
			end
		endcase
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eoi, input row_check_t chk,
			input logic [7:0] want_byte, input logic [1:0] want_st);
		result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		inputs_sent++;
		predict_unescape(b, eoi);
		if (chk == CHK_MODEL) begin
			foreach (step_out[i])
				expected_out.insert(expected_out.size(), step_out[i]);
		end else if (chk == CHK_ONE) begin
			r = '{want_byte, want_st, 1'b1};
			expected_out.insert(expected_out.size(), r);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// receiver side: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_req && !hold_used) begin
			hold_left = HOLD_CYCLES;
			hold_used = 1'b1;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser == ST_DONE)
				done_seen++;
			if (m_tuser == ST_ERR)
				err_seen++;
			if (expected_out.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer: byte %h status %0d last %0d",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = expected_out.pop_front();
				if (m_tdata !== want.out_byte)
					report_mismatch($sformatf("transfer %0d: out_byte %h, want %h",
						results_seen, m_tdata, want.out_byte));
				if (m_tuser !== want.status)
					report_mismatch($sformatf("transfer %0d: status %0d, want %0d",
						results_seen, m_tuser, want.status));
				if (m_tlast !== want.last_of_run)
					report_mismatch($sformatf("transfer %0d: last_of_run %0d, want %0d",
						results_seen, m_tlast, want.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_out.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].data, dir_rows[i].eoi, dir_rows[i].chk,
				dir_rows[i].want_byte, dir_rows[i].want_status);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 18;
					rx_idle_pct = 58;
				end
				1: begin
					tx_idle_pct = 58;
					rx_idle_pct = 18;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			stim_q.delete();
			while (stim_q.size() < ITEMS_PER_PHASE)
				gen_segment();
			foreach (stim_q[i])
				send_item(stim_q[i].data, stim_q[i].eoi, CHK_MODEL, 8'h00, ST_DATA);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d input transfers (%0d from the table), %0d output transfers checked",
			inputs_sent, $size(dir_rows), results_seen);
		$display("%0d strings closed, %0d error runs, stalls on both sides and one long hold-off",
			done_seen, err_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/tb_top.sv
